/* rtl/pds_pkg.sv */
`default_nettype none

package pds_pkg;

	localparam int FRAC_BITS = 16;
	localparam int TRANS_W = 32;
	localparam int ROT_W = 25;
	localparam int DT_W = 20;
	localparam int DTC_W = 17;
	localparam int TDZ_W = 31;
	localparam int RDZ_W = 24;
	localparam int TC_W = 24;
	localparam int DIVR_W = 25;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 31;
	localparam int N_TRANS = 3;
	localparam int N_ROT = 3;
	localparam int N_LANES = N_TRANS + N_ROT;

	localparam int HALF_TURN = 180 << FRAC_BITS;
	localparam int FULL_TURN = 360 << FRAC_BITS;
	localparam logic [DT_W-1:0] DT_MIN = DT_W'(100);
	localparam logic [DT_W-1:0] DT_MAX = DT_W'(100000);

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TRANS_DZ = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_ROT_DZ = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_TRANS_TC = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_ROT_TC = CFG_IDX_W'(4);

	typedef enum logic [1:0] {
		OP_PASS,
		OP_PASS_CLEAR,
		OP_PRIME,
		OP_FILTER
	} lane_op_t;

	typedef struct packed {
		logic start;
		lane_op_t op;
	} lane_ctrl_t;

	typedef enum logic [2:0] {
		LS_IDLE,
		LS_MUL,
		LS_LOAD,
		LS_DIV,
		LS_POST,
		LS_WRAP_MUL,
		LS_WRAP_OUT,
		LS_FIN
	} lane_state_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} top_state_t;

endpackage

`default_nettype wire

/* rtl/pds_if.sv */
`default_nettype none

interface pds_in_if;
	import pds_pkg::*;

	logic valid;
	logic ready;
	logic signed [TRANS_W-1:0] trans_x;
	logic signed [TRANS_W-1:0] trans_y;
	logic signed [TRANS_W-1:0] trans_z;
	logic signed [ROT_W-1:0] rot_x;
	logic signed [ROT_W-1:0] rot_y;
	logic signed [ROT_W-1:0] rot_z;
	logic [DT_W-1:0] dt_us;
	logic restart;

	modport source(output valid, trans_x, trans_y, trans_z, rot_x, rot_y, rot_z, dt_us,
		restart, input ready);
	modport sink(input valid, trans_x, trans_y, trans_z, rot_x, rot_y, rot_z, dt_us,
		restart, output ready);
endinterface

interface pds_out_if;
	import pds_pkg::*;

	logic valid;
	logic ready;
	logic signed [TRANS_W-1:0] out_trans_x;
	logic signed [TRANS_W-1:0] out_trans_y;
	logic signed [TRANS_W-1:0] out_trans_z;
	logic signed [ROT_W-1:0] out_rot_x;
	logic signed [ROT_W-1:0] out_rot_y;
	logic signed [ROT_W-1:0] out_rot_z;

	modport source(output valid, out_trans_x, out_trans_y, out_trans_z, out_rot_x, out_rot_y,
		out_rot_z, input ready);
	modport sink(input valid, out_trans_x, out_trans_y, out_trans_z, out_rot_x, out_rot_y,
		out_rot_z, output ready);
endinterface

`default_nettype wire

/* rtl/pose_deadzone_smoother_core.sv */
`default_nettype none

// Deadzone exponential smoother for a six-channel pose. Each of the six channels has its own
// lane with a bit-serial shift-subtract divider for the time-constant division, and the lanes
// run side by side on one pose. A filtered pose gives its result once every lane is done, and
// the next pose is taken only after that result moves to the output register; the translation
// lanes, whose 52-bit quotient takes one divider step per bit, are the slowest. A rotation lane
// whose sum leaves the +-180 degree range reduces the angle with a reciprocal multiplication
// in the extra states LS_WRAP_MUL and LS_WRAP_OUT and still finishes before the translation
// lanes. Pass-through and priming poses skip the divider and go straight to the finish state.
// One pose is in work at a time; the finished result sits in an output register so that the
// next pose can be taken while it waits, and a result still waiting there holds the next one.
module pose_deadzone_smoother_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [pds_pkg::CFG_IDX_W-1:0] cfg_idx,
	input wire logic [pds_pkg::CFG_DATA_W-1:0] cfg_data,
	pds_in_if.sink in_ch,
	pds_out_if.source out_ch
);
	import pds_pkg::*;

	top_state_t state_q, state_next;

	logic en_q;
	logic [TDZ_W-1:0] tdz_q;
	logic [RDZ_W-1:0] rdz_q;
	logic [TC_W-1:0] ttc_q;
	logic [TC_W-1:0] rtc_q;
	logic awaiting_q;
	logic [N_LANES-1:0] done_q;
	logic out_valid_q;
	logic signed [TRANS_W-1:0] otx_q, oty_q, otz_q;
	logic signed [ROT_W-1:0] orx_q, ory_q, orz_q;

	logic accept;
	logic load_out;
	lane_op_t op_sel;
	lane_ctrl_t ctrl;
	logic [DTC_W-1:0] dt_clamped;
	logic [N_LANES-1:0] lane_done;
	logic all_done;
	logic signed [TRANS_W-1:0] tv [N_TRANS];
	logic signed [TRANS_W-1:0] tres [N_TRANS];
	logic signed [ROT_W-1:0] rv [N_ROT];
	logic signed [ROT_W-1:0] rres [N_ROT];

	assign accept = in_ch.valid && in_ch.ready;

	always_comb begin
		if (!en_q) begin
			op_sel = in_ch.restart ? OP_PASS_CLEAR : OP_PASS;
		end else if (in_ch.restart || awaiting_q) begin
			op_sel = OP_PRIME;
		end else begin
			op_sel = OP_FILTER;
		end
		ctrl.start = accept;
		ctrl.op = op_sel;

		if (in_ch.dt_us < DT_MIN) begin
			dt_clamped = DTC_W'(DT_MIN);
		end else if (in_ch.dt_us > DT_MAX) begin
			dt_clamped = DTC_W'(DT_MAX);
		end else begin
			dt_clamped = in_ch.dt_us[DTC_W-1:0];
		end
	end

	assign tv[0] = in_ch.trans_x;
	assign tv[1] = in_ch.trans_y;
	assign tv[2] = in_ch.trans_z;
	assign rv[0] = in_ch.rot_x;
	assign rv[1] = in_ch.rot_y;
	assign rv[2] = in_ch.rot_z;

	for (genvar i = 0; i < N_TRANS; i++) begin : g_trans
		pds_lane #(
			.W(TRANS_W),
			.IS_ROT(1'b0),
			.DZ_W(TDZ_W)
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.v(tv[i]),
			.dt(dt_clamped),
			.dz(tdz_q),
			.tc(ttc_q),
			.done(lane_done[i]),
			.result(tres[i])
		);
	end

	for (genvar i = 0; i < N_ROT; i++) begin : g_rot
		pds_lane #(
			.W(ROT_W),
			.IS_ROT(1'b1),
			.DZ_W(RDZ_W)
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.v(rv[i]),
			.dt(dt_clamped),
			.dz(rdz_q),
			.tc(rtc_q),
			.done(lane_done[N_TRANS + i]),
			.result(rres[i])
		);
	end

	assign all_done = &(done_q | lane_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		in_ch.ready = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					state_next = ST_RUN;
				end
			end
			ST_RUN: begin
				if (all_done) begin
					state_next = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (!out_valid_q || out_ch.ready) begin
					load_out = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
			tdz_q <= '0;
			rdz_q <= '0;
			ttc_q <= TC_W'(1);
			rtc_q <= TC_W'(1);
			awaiting_q <= 1'b1;
			done_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_ENABLE: en_q <= cfg_data[0];
					REG_TRANS_DZ: tdz_q <= cfg_data[TDZ_W-1:0];
					REG_ROT_DZ: rdz_q <= cfg_data[RDZ_W-1:0];
					REG_TRANS_TC: ttc_q <= cfg_data[TC_W-1:0];
					REG_ROT_TC: rtc_q <= cfg_data[TC_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				done_q <= '0;
				if (!en_q && in_ch.restart) begin
					awaiting_q <= 1'b1;
				end else if (en_q) begin
					awaiting_q <= 1'b0;
				end
			end else if (state_q == ST_RUN) begin
				done_q <= done_q | lane_done;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			otx_q <= tres[0];
			oty_q <= tres[1];
			otz_q <= tres[2];
			orx_q <= rres[0];
			ory_q <= rres[1];
			orz_q <= rres[2];
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_trans_x = otx_q;
	assign out_ch.out_trans_y = oty_q;
	assign out_ch.out_trans_z = otz_q;
	assign out_ch.out_rot_x = orx_q;
	assign out_ch.out_rot_y = ory_q;
	assign out_ch.out_rot_z = orz_q;

endmodule

`default_nettype wire

/* rtl/pds_lane.sv */
`default_nettype none

module pds_lane #(
	parameter int W = 32,
	parameter bit IS_ROT = 1'b0,
	parameter int DZ_W = 31
) (
	input wire logic clk,
	input wire logic arst_n,
	input pds_pkg::lane_ctrl_t ctrl,
	input wire logic signed [W-1:0] v,
	input wire logic [pds_pkg::DTC_W-1:0] dt,
	input wire logic [DZ_W-1:0] dz,
	input wire logic [pds_pkg::TC_W-1:0] tc,
	output logic done,
	output logic signed [W-1:0] result
);
	import pds_pkg::*;

	localparam int MW = W + 1;
	localparam int PW = MW + DTC_W;
	localparam int DW = PW + 1;
	localparam int NB = DW + 1;
	localparam int NW = DW + 2;
	localparam int CW = $clog2(NB + 1);

	// A full turn is 45 << (FRAC_BITS + 3), so the angle reduction only needs the
	// upper bits taken modulo 45, done with an exact reciprocal multiplication.
	localparam int WRAP_DIV = 45;
	localparam int WR_W = 6;
	localparam int WSH = FRAC_BITS + 3;
	localparam int WX_W = NB - WSH;
	localparam int WQ_W = WX_W - 5;
	localparam int WS = WX_W + 6;
	localparam int WM_W = WX_W + 1;
	localparam int WP_W = 2 * WX_W + 1;
	localparam logic [WM_W-1:0] WMUL =
		WM_W'(((longint'(1) <<< WS) + longint'(WRAP_DIV - 1)) / longint'(WRAP_DIV));

	localparam logic signed [MW-1:0] HALF_D = MW'(HALF_TURN);
	localparam logic signed [MW-1:0] FULL_D = MW'(FULL_TURN);
	localparam logic [NW-1:0] HALF_N = NW'(HALF_TURN);
	localparam logic signed [NW-1:0] SAT_MAX = NW'((longint'(1) <<< (W - 1)) - longint'(1));
	localparam logic signed [NW-1:0] SAT_MIN = ~SAT_MAX;

	lane_state_t state_q, state_next;

	logic signed [W-1:0] held_q;
	logic signed [W-1:0] result_q;
	logic neg_q;
	logic [MW-1:0] mag_q;
	logic [DTC_W-1:0] dt_q;
	logic [TC_W-1:0] tc_q;
	logic [PW-1:0] prod_s1;
	logic [NB-1:0] num_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic wneg_q;
	logic [WX_W-1:0] wx_q;
	logic [WSH-1:0] wlo_q;
	logic [WQ_W-1:0] wq_s1;

	logic signed [MW-1:0] delta;
	logic signed [MW-1:0] dwrap;
	logic neg;
	logic [MW-1:0] mag;
	logic [MW-1:0] dz_ext;
	logic [MW-1:0] mag_net;
	logic [DIVR_W:0] shifted;
	logic [DIVR_W+1:0] trial;
	logic qbit;
	logic signed [NW-1:0] qs;
	logic signed [NW-1:0] held_ext;
	logic signed [NW-1:0] nv;
	logic [NW-1:0] anv;
	logic over;
	logic [NB-1:0] e_val;
	logic signed [NW-1:0] sat;
	logic [WP_W-1:0] wprod;
	logic [WQ_W-1:0] wquo;
	logic [WX_W-1:0] wrx;
	logic signed [MW-1:0] wrem;
	logic signed [MW-1:0] wres;
	logic signed [MW-1:0] wfinal;

	always_comb begin
		delta = signed'({v[W-1], v}) - signed'({held_q[W-1], held_q});
		dwrap = delta;
		if (IS_ROT) begin
			if (delta > HALF_D) begin
				dwrap = delta - FULL_D;
			end else if (delta < -HALF_D) begin
				dwrap = delta + FULL_D;
			end
		end
		neg = dwrap[MW-1];
		mag = neg ? MW'(-dwrap) : MW'(dwrap);
		dz_ext = MW'(dz);
		mag_net = (mag <= dz_ext) ? '0 : mag - dz_ext;

		shifted = {rem_q, num_q[NB-1]};
		trial = {1'b0, shifted} - {2'b00, div_q};
		qbit = ~trial[DIVR_W+1];

		qs = signed'({2'b00, num_q[DW-1:0]});
		held_ext = NW'(held_q);
		nv = held_ext + (neg_q ? -qs : qs);
		anv = nv[NW-1] ? NW'(-nv) : NW'(nv);
		over = anv > HALF_N;
		e_val = NB'(anv - HALF_N);

		if (nv > SAT_MAX) begin
			sat = SAT_MAX;
		end else if (nv < SAT_MIN) begin
			sat = SAT_MIN;
		end else begin
			sat = nv;
		end

		wprod = WP_W'(wx_q) * WP_W'(WMUL);
		wquo = wprod[WP_W-1:WS];
		wrx = wx_q - WX_W'(wq_s1) * WX_W'(WRAP_DIV);
		wrem = signed'(MW'({wrx[WR_W-1:0], wlo_q}));
		wres = (wrem == '0) ? HALF_D : wrem - HALF_D;
		wfinal = wneg_q ? -wres : wres;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LS_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		done = 1'b0;
		case (state_q)
			LS_IDLE: begin
				if (ctrl.start) begin
					state_next = (ctrl.op == OP_FILTER) ? LS_MUL : LS_FIN;
				end
			end
			LS_MUL: state_next = LS_LOAD;
			LS_LOAD: state_next = LS_DIV;
			LS_DIV: begin
				if (cnt_q == CW'(1)) begin
					state_next = LS_POST;
				end
			end
			LS_POST: state_next = (IS_ROT && over) ? LS_WRAP_MUL : LS_FIN;
			LS_WRAP_MUL: state_next = LS_WRAP_OUT;
			LS_WRAP_OUT: state_next = LS_FIN;
			LS_FIN: begin
				done = 1'b1;
				state_next = LS_IDLE;
			end
			default: state_next = LS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else begin
			case (state_q)
				LS_IDLE: begin
					if (ctrl.start) begin
						case (ctrl.op)
							OP_PASS: result_q <= v;
							OP_PASS_CLEAR: begin
								held_q <= '0;
								result_q <= v;
							end
							OP_PRIME: begin
								held_q <= v;
								result_q <= v;
							end
							OP_FILTER: begin
								neg_q <= neg;
								mag_q <= mag_net;
								dt_q <= dt;
								tc_q <= (tc == '0) ? TC_W'(1) : tc;
							end
							default: result_q <= v;
						endcase
					end
				end
				LS_MUL: prod_s1 <= mag_q * dt_q;
				LS_LOAD: begin
					num_q <= NB'(prod_s1) + NB'(tc_q >> 1);
					rem_q <= '0;
					div_q <= DIVR_W'(tc_q);
					cnt_q <= CW'(NB);
				end
				LS_DIV: begin
					rem_q <= qbit ? trial[DIVR_W-1:0] : shifted[DIVR_W-1:0];
					num_q <= {num_q[NB-2:0], qbit};
					cnt_q <= cnt_q - CW'(1);
				end
				LS_POST: begin
					if (IS_ROT) begin
						if (over) begin
							wx_q <= e_val[NB-1:WSH];
							wlo_q <= e_val[WSH-1:0];
							wneg_q <= nv[NW-1];
						end else begin
							held_q <= W'(nv);
							result_q <= W'(nv);
						end
					end else begin
						held_q <= W'(sat);
						result_q <= W'(sat);
					end
				end
				LS_WRAP_MUL: wq_s1 <= wquo;
				LS_WRAP_OUT: begin
					held_q <= W'(wfinal);
					result_q <= W'(wfinal);
				end
				default: ;
			endcase
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire
